// ----- sv/bpc_pkg.sv -----
// Shared types and constants for the barometric compensation pipeline.
// Holds field widths, the coefficient register map and the coefficient bundle.
// No dependencies.
package bpc_pkg;

  localparam int RAW_W      = 24;  // raw pressure and temperature readings
  localparam int CFG_W      = 24;  // widest coefficient register
  localparam int PRES_OUT_W = 40;
  localparam int TEMP_OUT_W = 25;
  localparam int FRAC_W     = 8;   // fraction bits of both results
  localparam int COEF_T_W   = 12;  // c0 and c1
  localparam int COEF_L_W   = 20;  // c00 and c10
  localparam int COEF_S_W   = 16;  // c01, c11, c20, c21, c30
  localparam int CHUNK_W    = 24;  // slice width of the wide multiplier operand
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TEMP_COEF_PAIR    = 3'd0,
    REG_PRES_OFFSET_COEF  = 3'd1,
    REG_PRES_LINEAR_COEF  = 3'd2,
    REG_TEMP_CROSS_COEF   = 3'd3,
    REG_MIXED_LINEAR_COEF = 3'd4,
    REG_PRES_SQUARE_COEF  = 3'd5,
    REG_MIXED_SQUARE_COEF = 3'd6,
    REG_PRES_CUBE_COEF    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COEF_T_W-1:0] c0;
    logic signed [COEF_T_W-1:0] c1;
    logic signed [COEF_L_W-1:0] c00;
    logic signed [COEF_L_W-1:0] c10;
    logic signed [COEF_S_W-1:0] c01;
    logic signed [COEF_S_W-1:0] c11;
    logic signed [COEF_S_W-1:0] c20;
    logic signed [COEF_S_W-1:0] c21;
    logic signed [COEF_S_W-1:0] c30;
  } coef_t;

endpackage

// ----- sv/baro_pressure_temp_compensation.sv -----
// Barometric pressure and temperature compensation, fixed-point polynomial pipeline.
// Send one raw pressure / raw temperature pair per request on the input channel
// (in_valid_i, in_stall_o); the compensated pair comes back on the output channel
// (out_valid_o, out_stall_i), both results signed with 8 fraction bits.
// Coefficients are loaded through the write port (cfg_we_i, cfg_addr_i, cfg_wdata_i)
// by the user only while no request is in flight; the block does not enforce this.
// Throughput: one request per cycle while in_stall_o is low. The pipeline is set
// by the three-deep Horner chain in pressure; each multiply-add takes two stages
// (sliced partial products, then their sum), plus an input stage and the final
// alignment stage.
// When the receiver stalls, the result holds on the outputs and bubbles inside the
// pipeline still fill, so new requests are taken until every stage is occupied.
// Reset clears all stage valid bits and all coefficients to zero.
// Depends on bpc_pkg, bpc_cfg and bpc_mac.
module baro_pressure_temp_compensation
  import bpc_pkg::*;
#(
  parameter int PRES_SCALE_SHIFT = 19,
  parameter int TEMP_SCALE_SHIFT = 19
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [RAW_W-1:0]      raw_pres_i,
  input  logic signed [RAW_W-1:0]      raw_temper_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [PRES_OUT_W-1:0] pressure_out_o,
  output logic signed [TEMP_OUT_W-1:0] temperature_out_o
);

  localparam int PS        = PRES_SCALE_SHIFT;
  localparam int TS        = TEMP_SCALE_SHIFT;
  localparam int NumStages = 8;
  localparam int CarryLen  = 5;  // raw readings are needed up to the fifth stage
  localparam int TresLen   = 5;
  localparam int MulW      = RAW_W + COEF_S_W;
  localparam int H1W = ((MulW > COEF_S_W + PS) ? MulW : COEF_S_W + PS) + 1;
  localparam int H2W = ((RAW_W + H1W > COEF_L_W + 2*PS) ? RAW_W + H1W
                                                        : COEF_L_W + 2*PS) + 1;
  localparam int H3W = ((RAW_W + H2W > COEF_L_W + 3*PS) ? RAW_W + H2W
                                                        : COEF_L_W + 3*PS) + 1;
  localparam int G2W = ((RAW_W + H1W > COEF_S_W + 2*PS) ? RAW_W + H1W
                                                        : COEF_S_W + 2*PS) + 1;
  localparam int G3W = RAW_W + G2W;
  localparam int E   = 3*PS + TS;  // common exponent of the pressure sum
  localparam int SW  = E - FRAC_W + PRES_OUT_W;
  localparam int TW  = TS - FRAC_W + TEMP_OUT_W;

  coef_t coef;

  logic [NumStages-1:0] vld_q, vld_d, adv;

  logic signed [RAW_W-1:0]      p_q [CarryLen];
  logic signed [RAW_W-1:0]      t_q [CarryLen];
  logic signed [TEMP_OUT_W-1:0] tres_q [TresLen];
  logic signed [PRES_OUT_W-1:0] pres_q;

  logic signed [H1W-1:0] h1_y, g1_y;
  logic signed [H2W-1:0] h2_y;
  logic signed [G2W-1:0] g2_y;
  logic signed [H3W-1:0] h3_y;
  logic signed [G3W-1:0] g3_y;
  logic signed [TW-1:0]  temp_y;
  logic signed [SW-1:0]  sum;

  bpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coef_o     (coef)
  );

  // A stage advances when it is empty or the next one advances.
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o = !adv[0];

  // Carry the raw readings alongside the multiply chain.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      p_q[0] <= raw_pres_i;
      t_q[0] <= raw_temper_i;
    end
    for (int k = 1; k < CarryLen; k++) begin
      if (adv[k]) begin
        p_q[k] <= p_q[k-1];
        t_q[k] <= t_q[k-1];
      end
    end
  end

  // Stages 1-2: c30*P + c20, c21*P + c11, c1*T + c0/2
  bpc_mac #(.AW(COEF_S_W), .CW(COEF_S_W), .K(PS), .OW(H1W)) u_h1 (
    .clk_i(clk_i), .en_i(adv[2:1]), .a_i(coef.c30), .b_i(p_q[0]),
    .c_i(coef.c20), .y_o(h1_y)
  );

  bpc_mac #(.AW(COEF_S_W), .CW(COEF_S_W), .K(PS), .OW(H1W)) u_g1 (
    .clk_i(clk_i), .en_i(adv[2:1]), .a_i(coef.c21), .b_i(p_q[0]),
    .c_i(coef.c11), .y_o(g1_y)
  );

  bpc_mac #(.AW(COEF_T_W), .CW(COEF_T_W), .K(TS - 1), .OW(TW)) u_temp (
    .clk_i(clk_i), .en_i(adv[2:1]), .a_i(coef.c1), .b_i(t_q[0]),
    .c_i(coef.c0), .y_o(temp_y)
  );

  // Stages 3-4: fold in the linear pressure and temperature coefficients.
  bpc_mac #(.AW(H1W), .CW(COEF_L_W), .K(2*PS), .OW(H2W)) u_h2 (
    .clk_i(clk_i), .en_i(adv[4:3]), .a_i(h1_y), .b_i(p_q[2]),
    .c_i(coef.c10), .y_o(h2_y)
  );

  bpc_mac #(.AW(H1W), .CW(COEF_S_W), .K(2*PS), .OW(G2W)) u_g2 (
    .clk_i(clk_i), .en_i(adv[4:3]), .a_i(g1_y), .b_i(p_q[2]),
    .c_i(coef.c01), .y_o(g2_y)
  );

  // Stages 5-6: offset term and the temperature-scaled branch.
  bpc_mac #(.AW(H2W), .CW(COEF_L_W), .K(3*PS), .OW(H3W)) u_h3 (
    .clk_i(clk_i), .en_i(adv[6:5]), .a_i(h2_y), .b_i(p_q[4]),
    .c_i(coef.c00), .y_o(h3_y)
  );

  bpc_mac #(.AW(G2W), .CW(1), .K(0), .OW(G3W)) u_g3 (
    .clk_i(clk_i), .en_i(adv[6:5]), .a_i(g2_y), .b_i(t_q[4]),
    .c_i(1'sb0), .y_o(g3_y)
  );

  // Temperature is done after stage 2; hold its bits until the output stage.
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      tres_q[0] <= temp_y[TS-FRAC_W +: TEMP_OUT_W];
    end
    for (int k = 1; k < TresLen; k++) begin
      if (adv[k+3]) begin
        tres_q[k] <= tres_q[k-1];
      end
    end
  end

  // Stage 7: align both branches to the common exponent and floor to 8 fraction bits.
  assign sum = (SW'(h3_y) <<< TS) + (SW'(g3_y) <<< PS);

  always_ff @(posedge clk_i) begin
    if (adv[NumStages-1]) begin
      pres_q <= sum[E-FRAC_W +: PRES_OUT_W];
    end
  end

  assign out_valid_o       = vld_q[NumStages-1];
  assign pressure_out_o    = pres_q;
  assign temperature_out_o = tres_q[TresLen-1];

endmodule

// ----- sv/bpc_cfg.sv -----
// Calibration coefficient registers, written through a plain write port.
// Unpacks the temperature pair and drops bits above each register width.
// Depends on bpc_pkg.
module bpc_cfg
  import bpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output coef_t                 coef_o
);

  coef_t coef_d, coef_q;

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_TEMP_COEF_PAIR: begin
          coef_d.c0 = cfg_wdata_i[2*COEF_T_W-1:COEF_T_W];
          coef_d.c1 = cfg_wdata_i[COEF_T_W-1:0];
        end
        REG_PRES_OFFSET_COEF:  coef_d.c00 = cfg_wdata_i[COEF_L_W-1:0];
        REG_PRES_LINEAR_COEF:  coef_d.c10 = cfg_wdata_i[COEF_L_W-1:0];
        REG_TEMP_CROSS_COEF:   coef_d.c01 = cfg_wdata_i[COEF_S_W-1:0];
        REG_MIXED_LINEAR_COEF: coef_d.c11 = cfg_wdata_i[COEF_S_W-1:0];
        REG_PRES_SQUARE_COEF:  coef_d.c20 = cfg_wdata_i[COEF_S_W-1:0];
        REG_MIXED_SQUARE_COEF: coef_d.c21 = cfg_wdata_i[COEF_S_W-1:0];
        REG_PRES_CUBE_COEF:    coef_d.c30 = cfg_wdata_i[COEF_S_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ----- sv/bpc_mac.sv -----
// Two-stage multiply-add y = a * b + (c << K) on signed operands.
// Stage one registers 25x24 partial products of a sliced operand, stage two sums them.
// Depends on bpc_pkg.
module bpc_mac
  import bpc_pkg::*;
#(
  parameter int AW = 16,  // width of the sliced operand a
  parameter int CW = 16,  // width of the addend c
  parameter int K  = 19,  // left shift of the addend
  parameter int OW = 41   // result width, wraps above
) (
  input  logic                    clk_i,
  input  logic [1:0]              en_i,  // load enables of the product and sum stages
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [RAW_W-1:0] b_i,
  input  logic signed [CW-1:0]    c_i,
  output logic signed [OW-1:0]    y_o
);

  localparam int NumChunks = (AW + CHUNK_W - 1) / CHUNK_W;
  localparam int ExtW      = NumChunks * CHUNK_W;
  localparam int PW        = CHUNK_W + 1 + RAW_W;

  logic signed [ExtW-1:0] a_ext;
  logic signed [PW-1:0]   pp_q [NumChunks];
  logic signed [OW-1:0]   y_d, y_q;

  assign a_ext = ExtW'(a_i);

  for (genvar gi = 0; gi < NumChunks; gi++) begin : g_pp
    logic signed [CHUNK_W:0] op_a;
    logic signed [PW-1:0]    pp_d;
    if (gi == NumChunks - 1) begin : g_top
      // top slice carries the sign
      assign op_a = {a_ext[gi*CHUNK_W+CHUNK_W-1], a_ext[gi*CHUNK_W +: CHUNK_W]};
    end else begin : g_low
      assign op_a = {1'b0, a_ext[gi*CHUNK_W +: CHUNK_W]};
    end
    assign pp_d = op_a * b_i;
    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        pp_q[gi] <= pp_d;
      end
    end
  end

  always_comb begin
    y_d = OW'(c_i) <<< K;
    for (int i = 0; i < NumChunks; i++) begin
      y_d = y_d + (OW'(pp_q[i]) <<< (i * CHUNK_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// ----- tb/sv/baro_pressure_temp_compensation_tb.sv -----
`timescale 1ns / 1ps
// Testbench for baro_pressure_temp_compensation: streams raw reading pairs under several
// coefficient sets and checks each compensated pair against an in-bench fixed-point model.
// Depends on bpc_pkg and the block's RTL.
module baro_pressure_temp_compensation_tb;
  import bpc_pkg::*;

  localparam int PRES_SHIFT    = 19;
  localparam int TEMP_SHIFT    = 19;
  localparam int LATENCY       = 8;
  localparam int IDLE_PCT      = 35;
  localparam int ITEMS_PER_SET = 315;
  localparam int PRES_EXP      = 3 * PRES_SHIFT + TEMP_SHIFT;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [PRES_OUT_W-1:0] pressure;
    logic [TEMP_OUT_W-1:0] temperature;
  } reading_t;

  typedef enum int {SET_MAX, SET_MIN, SET_ALL_ONES, SET_ALT_SIGN, SET_RANDOM} coef_set_e;

  class compensation_board;
    wide_t c0, c1, c00, c10, c01, c11, c20, c21, c30;
    reading_t pending[$];
    int errors;

    function new();
      c0 = '0; c1 = '0; c00 = '0; c10 = '0; c01 = '0;
      c11 = '0; c20 = '0; c21 = '0; c30 = '0;
      errors = 0;
    endfunction

    // drop bits above each register's width, then sign-extend
    function void load_coef(cfg_reg_e idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_TEMP_COEF_PAIR: begin
          c0 = wide_t'($signed(d[2*COEF_T_W-1:COEF_T_W]));
          c1 = wide_t'($signed(d[COEF_T_W-1:0]));
        end
        REG_PRES_OFFSET_COEF:  c00 = wide_t'($signed(d[COEF_L_W-1:0]));
        REG_PRES_LINEAR_COEF:  c10 = wide_t'($signed(d[COEF_L_W-1:0]));
        REG_TEMP_CROSS_COEF:   c01 = wide_t'($signed(d[COEF_S_W-1:0]));
        REG_MIXED_LINEAR_COEF: c11 = wide_t'($signed(d[COEF_S_W-1:0]));
        REG_PRES_SQUARE_COEF:  c20 = wide_t'($signed(d[COEF_S_W-1:0]));
        REG_MIXED_SQUARE_COEF: c21 = wide_t'($signed(d[COEF_S_W-1:0]));
        REG_PRES_CUBE_COEF:    c30 = wide_t'($signed(d[COEF_S_W-1:0]));
        default: ;
      endcase
    endfunction

    // exact polynomial over a common power-of-two denominator, then floor to Q.8
    function reading_t compensate(logic signed [RAW_W-1:0] p, logic signed [RAW_W-1:0] t);
      wide_t rp, rt, p2, p3, tp, tp2, acc, tacc;
      reading_t r;
      rp   = wide_t'(p);
      rt   = wide_t'(t);
      p2   = rp * rp;
      p3   = p2 * rp;
      tp   = rt * rp;
      tp2  = rt * p2;
      acc  = c00 <<< PRES_EXP;
      acc += (c10 * rp) <<< (2 * PRES_SHIFT + TEMP_SHIFT);
      acc += (c20 * p2) <<< (PRES_SHIFT + TEMP_SHIFT);
      acc += (c30 * p3) <<< TEMP_SHIFT;
      acc += (c01 * rt) <<< (3 * PRES_SHIFT);
      acc += (c11 * tp) <<< (2 * PRES_SHIFT);
      acc += (c21 * tp2) <<< PRES_SHIFT;
      acc  = acc >>> (PRES_EXP - FRAC_W);
      tacc = (c0 <<< (TEMP_SHIFT - 1)) + c1 * rt;
      tacc = tacc >>> (TEMP_SHIFT - FRAC_W);
      r.pressure    = acc[PRES_OUT_W-1:0];
      r.temperature = tacc[TEMP_OUT_W-1:0];
      return r;
    endfunction

    function void note_reading(logic signed [RAW_W-1:0] p, logic signed [RAW_W-1:0] t);
      pending.push_back(compensate(p, t));
    endfunction

    function void check_reading(logic [PRES_OUT_W-1:0] pres, logic [TEMP_OUT_W-1:0] temp);
      reading_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result: pressure %h temperature %h", $time, pres, temp);
        return;
      end
      want = pending.pop_front();
      if (pres !== want.pressure) begin
        errors++;
        $display("%0t pressure mismatch: expected %h, actual %h", $time, want.pressure, pres);
      end
      if (temp !== want.temperature) begin
        errors++;
        $display("%0t temperature mismatch: expected %h, actual %h", $time,
                 want.temperature, temp);
      end
    endfunction
  endclass

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_we_i     = 1'b0;
  logic [CFG_ADDR_W-1:0]        cfg_addr_i   = '0;
  logic [CFG_W-1:0]             cfg_wdata_i  = '0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_stall_o;
  logic signed [RAW_W-1:0]      raw_pres_i   = '0;
  logic signed [RAW_W-1:0]      raw_temper_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i  = 1'b0;
  logic signed [PRES_OUT_W-1:0] pressure_out_o;
  logic signed [TEMP_OUT_W-1:0] temperature_out_o;

  logic steady = 1'b0;  // no random idling on either side while set
  compensation_board book;

  baro_pressure_temp_compensation #(
    .PRES_SCALE_SHIFT(PRES_SHIFT),
    .TEMP_SCALE_SHIFT(TEMP_SHIFT)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_pres_i       (raw_pres_i),
    .raw_temper_i     (raw_temper_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pressure_out_o   (pressure_out_o),
    .temperature_out_o(temperature_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[baro_pressure_temp_compensation] ERROR");
    $finish;
  end

  task automatic send_reading(input logic signed [RAW_W-1:0] p,
                              input logic signed [RAW_W-1:0] t);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_pres_i   <= p;
    raw_temper_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    book.note_reading(p, t);
  endtask

  // drop valid, drain every pending result, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic load_coef_set(input coef_set_e kind);
    logic [CFG_W-1:0] d;
    cfg_reg_e idx;
    drain();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_e'(i);
      case (kind)
        SET_MAX: begin
          d = (idx == REG_TEMP_COEF_PAIR) ? 24'h7FF7FF :
              (idx inside {REG_PRES_OFFSET_COEF, REG_PRES_LINEAR_COEF}) ? 24'h07FFFF : 24'h007FFF;
        end
        SET_MIN: begin
          d = (idx == REG_TEMP_COEF_PAIR) ? 24'h800800 :
              (idx inside {REG_PRES_OFFSET_COEF, REG_PRES_LINEAR_COEF}) ? 24'h080000 : 24'h008000;
        end
        SET_ALL_ONES: d = 24'hFFFFFF;
        SET_ALT_SIGN: begin
          d = (idx == REG_TEMP_COEF_PAIR) ? 24'h7FF800 :
              (i % 2 == 0) ? 24'hF07FFF : 24'hA98000;
        end
        default: d = CFG_W'($urandom);
      endcase
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx;
      cfg_wdata_i <= d;
      @(posedge clk_i);
      book.load_coef(idx, d);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [RAW_W-1:0] pick_raw();
    logic signed [RAW_W-1:0] v;
    case ($urandom_range(9))
      0: v = $urandom_range(1) ? RAW_W'(24'h7FFFFF - $urandom_range(255))
                               : RAW_W'(24'h800000 + $urandom_range(255));
      1, 2: begin
        v = RAW_W'($urandom_range(511));
        v = v - 24'sd256;
      end
      default: v = RAW_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_reading(pick_raw(), pick_raw());
  endtask

  task automatic run_corners();
    logic signed [RAW_W-1:0] corner[4];
    corner = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF};
    foreach (corner[i]) foreach (corner[j]) send_reading(corner[i], corner[j]);
  endtask

  initial begin : receiver
    int rx_cycle;
    int hold_left;
    rx_cycle  = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (out_valid_o && !out_stall_i) begin
        book.check_reading(pressure_out_o, temperature_out_o);
      end
      // hold off long enough for the pipeline to fill and stall requests
      if (rx_cycle % 2500 == 1200) hold_left = 150;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    book = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients are all zero
    run_random(60);

    load_coef_set(SET_MAX);
    run_corners();
    run_random(ITEMS_PER_SET);

    load_coef_set(SET_MIN);
    run_random(ITEMS_PER_SET);

    load_coef_set(SET_ALL_ONES);
    run_random(ITEMS_PER_SET);

    load_coef_set(SET_ALT_SIGN);
    steady = 1'b1;
    run_random(150);
    steady = 1'b0;
    run_random(ITEMS_PER_SET - 150);

    load_coef_set(SET_RANDOM);
    run_random(ITEMS_PER_SET);

    load_coef_set(SET_RANDOM);
    run_random(ITEMS_PER_SET);

    drain();
    if (book.errors == 0) begin
      $display("[baro_pressure_temp_compensation] OK");
    end else begin
      $display("[baro_pressure_temp_compensation] ERROR");
    end
    $finish;
  end

endmodule
